// ===== design/skb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skb_pkg
// shared constants, register codes and the job record passed from the
// front end through the job queue to the write generator
// ----------------------------------------------------------------------------
package skb_pkg;

  // default geometry
  localparam int DEF_FB_WIDTH      = 1024;
  localparam int DEF_MAX_SCALE     = 8;
  localparam int DEF_MAX_IMAGE_DIM = 4096;
  localparam int DEF_QUEUE_DEPTH   = 4;

  // field widths
  localparam int COORD_W   = 18;  // signed destination coordinate, no overflow possible
  localparam int IDX_W     = 24;
  localparam int REF_W     = 32;
  localparam int CNT_W     = 3;   // extent of a block minus one, scale never above 8
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = 4'd7;

  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [3:0]         scale_x;
    logic [3:0]         scale_y;
    logic signed [15:0] clip_left;
    logic signed [15:0] clip_top;
    logic signed [15:0] clip_right;
    logic signed [15:0] clip_bottom;
  } skb_cfg_t;

  // one clipped block: first index, columns-1, rows-1, value to write
  typedef struct packed {
    logic [IDX_W-1:0] idx0;
    logic [CNT_W-1:0] nx;
    logic [CNT_W-1:0] ny;
    logic [REF_W-1:0] wref;
  } skb_job_t;

endpackage

// ===== design/scaled_keyed_blit_clipped_unit.sv =====
// an opaque pixel that is kept passes the stage 1 and stage 2 registers, the job queue and the
//   walker's index register before its first write is registered on the ports; a dropped pixel makes no job
// the write walker issues one write per cycle while its output register is free or being popped
// blocks run back to back; the front end keeps accepting while up to 4 jobs wait
// reset: synchronous, clears all queues and restores registers to origin 0, scale 1, clip 0
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_keyed_blit_clipped_unit
// scaled, color-keyed sprite blit with rectangular clipping: one source pixel
// in, a run of framebuffer index/value writes out
// ----------------------------------------------------------------------------
module scaled_keyed_blit_clipped_unit #(
  parameter int FB_WIDTH      = skb_pkg::DEF_FB_WIDTH,
  parameter int MAX_SCALE     = skb_pkg::DEF_MAX_SCALE,
  parameter int MAX_IMAGE_DIM = skb_pkg::DEF_MAX_IMAGE_DIM
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [skb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [skb_pkg::CFG_DAT_W-1:0] cfg_data,
  // source pixel beats
  input  logic                          push,
  output logic                          full,
  input  logic [11:0]                   src_x,
  input  logic [11:0]                   src_y,
  input  logic [31:0]                   pixel_word,
  input  logic [31:0]                   src_ref,
  // framebuffer write beats
  output logic                          empty,
  input  logic                          pop,
  output logic [23:0]                   dest_index,
  output logic [31:0]                   write_ref,
  output logic                          last
);
  import skb_pkg::*;

  skb_cfg_t cfg;
  logic     q_push, q_full, q_valid, q_pop;
  skb_job_t push_job, head_job;

  // register file: always ready, unknown indexes are ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x    <= '0;
      cfg.origin_y    <= '0;
      cfg.scale_x     <= 4'd1;
      cfg.scale_y     <= 4'd1;
      cfg.clip_left   <= '0;
      cfg.clip_top    <= '0;
      cfg.clip_right  <= '0;
      cfg.clip_bottom <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ORIGIN_X:    cfg.origin_x    <= cfg_data;
        REG_ORIGIN_Y:    cfg.origin_y    <= cfg_data;
        REG_SCALE_X:     cfg.scale_x     <= cfg_data[3:0];
        REG_SCALE_Y:     cfg.scale_y     <= cfg_data[3:0];
        REG_CLIP_LEFT:   cfg.clip_left   <= cfg_data;
        REG_CLIP_TOP:    cfg.clip_top    <= cfg_data;
        REG_CLIP_RIGHT:  cfg.clip_right  <= cfg_data;
        REG_CLIP_BOTTOM: cfg.clip_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  // front end: key test, image bounds, block placement and clipping
  skb_front #(
    .FB_WIDTH      (FB_WIDTH),
    .MAX_SCALE     (MAX_SCALE),
    .MAX_IMAGE_DIM (MAX_IMAGE_DIM)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .full       (full),
    .src_x      (src_x),
    .src_y      (src_y),
    .pixel_word (pixel_word),
    .src_ref    (src_ref),
    .q_push     (q_push),
    .q_job      (push_job),
    .q_full     (q_full)
  );

  // decouples placement from the write walk so either side can stall
  skb_queue #(
    .DEPTH (DEF_QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_push),
    .wr_job (push_job),
    .full   (q_full),
    .rd     (q_pop),
    .rd_job (head_job),
    .valid  (q_valid)
  );

  // back end: one write per cycle while the output is free, row-major, last flag on the final one
  skb_back #(
    .FB_WIDTH (FB_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_job      (head_job),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .dest_index (dest_index),
    .write_ref  (write_ref),
    .last       (last)
  );

endmodule

// ===== design/skb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skb_front
// takes source pixels, drops transparent, zero-scale and out-of-image ones, places the
// scaled block, clips it and hands a job record to the queue if any of the block is left
module skb_front #(
  parameter int FB_WIDTH      = skb_pkg::DEF_FB_WIDTH,
  parameter int MAX_SCALE     = skb_pkg::DEF_MAX_SCALE,
  parameter int MAX_IMAGE_DIM = skb_pkg::DEF_MAX_IMAGE_DIM
) (
  input  logic                      clk,
  input  logic                      rst,
  input  skb_pkg::skb_cfg_t         cfg,
  input  logic                      push,
  output logic                      full,
  input  logic [11:0]               src_x,
  input  logic [11:0]               src_y,
  input  logic [31:0]               pixel_word,
  input  logic [skb_pkg::REF_W-1:0] src_ref,
  output logic                      q_push,
  output skb_pkg::skb_job_t         q_job,
  input  logic                      q_full
);
  import skb_pkg::*;

  localparam logic [3:0] SCALE_LIM = 4'(MAX_SCALE);

  // stage 1: block origin
  logic [3:0]                sxe, sye;
  logic [15:0]               prod_x, prod_y;
  logic                      in_ok;
  logic                      s1_valid;
  logic signed [COORD_W-1:0] s1_bx, s1_by;
  logic [3:0]                s1_sx, s1_sy;
  logic [REF_W-1:0]          s1_ref;
  logic                      s1_ready;

  // stage 2: clipped extents
  logic signed [COORD_W-1:0] ex, ey, cl, ct, cr, cb;
  logic signed [COORD_W-1:0] x0, x1, y0, y1;
  logic                      keep;
  logic                      s2_valid;
  logic signed [COORD_W-1:0] s2_x0, s2_x1, s2_y0, s2_y1;
  logic [REF_W-1:0]          s2_ref;
  logic                      s2_ready;

  always_comb begin
    sxe    = (cfg.scale_x > SCALE_LIM) ? SCALE_LIM : cfg.scale_x;
    sye    = (cfg.scale_y > SCALE_LIM) ? SCALE_LIM : cfg.scale_y;
    prod_x = 16'(src_x) * 16'(sxe);
    prod_y = 16'(src_y) * 16'(sye);
    in_ok  = (pixel_word != 32'd0) && (sxe != 4'd0) && (sye != 4'd0) &&
             ({1'b0, src_x} < 13'(MAX_IMAGE_DIM)) &&
             ({1'b0, src_y} < 13'(MAX_IMAGE_DIM));
  end

  assign s2_ready = !s2_valid || !q_full;
  assign s1_ready = !s1_valid || s2_ready;
  assign full     = !s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= push && in_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_bx  <= COORD_W'(cfg.origin_x) + $signed({2'b00, prod_x});
      s1_by  <= COORD_W'(cfg.origin_y) + $signed({2'b00, prod_y});
      s1_sx  <= sxe;
      s1_sy  <= sye;
      s1_ref <= src_ref;
    end
  end

  always_comb begin
    ex   = s1_bx + $signed({14'd0, s1_sx}) - 18'sd1;
    ey   = s1_by + $signed({14'd0, s1_sy}) - 18'sd1;
    cl   = COORD_W'(cfg.clip_left);
    ct   = COORD_W'(cfg.clip_top);
    cr   = COORD_W'(cfg.clip_right);
    cb   = COORD_W'(cfg.clip_bottom);
    x0   = (s1_bx > cl) ? s1_bx : cl;
    x1   = (ex < cr) ? ex : cr;
    y0   = (s1_by > ct) ? s1_by : ct;
    y1   = (ey < cb) ? ey : cb;
    keep = (x0 <= x1) && (y0 <= y1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_x0  <= x0;
      s2_x1  <= x1;
      s2_y0  <= y0;
      s2_y1  <= y1;
      s2_ref <= s1_ref;
    end
  end

  // first index of the block, taken modulo the index width
  always_comb begin
    q_push     = s2_valid && !q_full;
    q_job.idx0 = IDX_W'(s2_x0) + IDX_W'(FB_WIDTH) * IDX_W'(s2_y0);
    q_job.nx   = CNT_W'(s2_x1 - s2_x0);
    q_job.ny   = CNT_W'(s2_y1 - s2_y0);
    q_job.wref = s2_ref;
  end

endmodule

// ===== design/skb_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skb_queue
// small show-ahead job queue between the front end and the write generator
// ----------------------------------------------------------------------------
module skb_queue #(
  parameter int DEPTH = skb_pkg::DEF_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  skb_pkg::skb_job_t wr_job,
  output logic              full,
  input  logic              rd,
  output skb_pkg::skb_job_t rd_job,
  output logic              valid
);
  import skb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  skb_job_t          slots [DEPTH];
  logic [PTR_W-1:0]  wptr, rptr;
  logic [CNT_QW-1:0] count;
  logic              do_wr, do_rd;

  assign full   = (count == CNT_QW'(DEPTH));
  assign valid  = (count != '0);
  assign do_wr  = wr && !full;
  assign do_rd  = rd && valid;
  assign rd_job = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_job;
    end
  end

endmodule

// ===== design/skb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skb_back
// walks each clipped block row by row and emits one framebuffer write beat
// per cycle into the output register whenever that register is empty or being popped
// ----------------------------------------------------------------------------
module skb_back #(
  parameter int FB_WIDTH = skb_pkg::DEF_FB_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  skb_pkg::skb_job_t         q_job,
  output logic                      q_pop,
  output logic                      empty,
  input  logic                      pop,
  output logic [skb_pkg::IDX_W-1:0] dest_index,
  output logic [skb_pkg::REF_W-1:0] write_ref,
  output logic                      last
);
  import skb_pkg::*;

  localparam logic [IDX_W-1:0] ROW_STEP = IDX_W'(FB_WIDTH);

  logic             active;
  logic             out_valid;
  logic [CNT_W-1:0] cc, rc, nx, ny;
  logic [IDX_W-1:0] idx, row_idx;
  logic [REF_W-1:0] wref;
  logic             beat_last, out_free, step, load;

  always_comb begin
    beat_last = (cc == nx) && (rc == ny);
    out_free  = !out_valid || pop;
    step      = active && out_free;
    load      = q_valid && (!active || (step && beat_last));
    q_pop     = load;
    empty     = !out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
      cc        <= '0;
      rc        <= '0;
      nx        <= '0;
      ny        <= '0;
    end else begin
      if (step) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        active <= 1'b1;
        cc     <= '0;
        rc     <= '0;
        nx     <= q_job.nx;
        ny     <= q_job.ny;
      end else if (step) begin
        if (beat_last) begin
          active <= 1'b0;
        end
        if (cc == nx) begin
          cc <= '0;
          rc <= rc + 1'b1;
        end else begin
          cc <= cc + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      dest_index <= idx;
      write_ref  <= wref;
      last       <= beat_last;
    end
    if (load) begin
      idx     <= q_job.idx0;
      row_idx <= q_job.idx0;
      wref    <= q_job.wref;
    end else if (step) begin
      if (cc == nx) begin
        row_idx <= row_idx + ROW_STEP;
        idx     <= row_idx + ROW_STEP;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  // counters stay inside the block being walked
  a_cnt_in_block: assert property (@(posedge clk) disable iff (rst)
    active |-> (cc <= nx) && (rc <= ny))
    else $error("block counter outside its extent");

  // a finished block with nothing queued leaves the walker idle
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    step && beat_last && !q_valid |=> !active)
    else $error("walker still active after last beat");

  // index only moves when a beat is produced or a block is loaded
  a_idx_hold: assert property (@(posedge clk) disable iff (rst)
    !step && !load |=> $stable(idx))
    else $error("index moved without a beat");

endmodule
